// File: src/pse_pkg.sv
// Shared constants, types and helper functions of the postfix stack evaluator.
package pse_pkg;

  localparam int STACK_DEPTH     = 16;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_POWER_STEPS = 31;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int QW  = 32 + FRAC_BITS;
  localparam int CW  = $clog2(QW + 1);
  localparam int PSW = $clog2(MAX_POWER_STEPS + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIV0  = 2'd3;

  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_POW  = 8'h5E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN64 = 64'shFFFF_FFFF_8000_0000;
  localparam logic [63:0] LOW_MASK = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic [QW-1:0] QMAX_MAG = QW'(64'h7FFF_FFFF);
  localparam logic [QW-1:0] QMIN_MAG = QW'(64'h8000_0000);

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    SYM_DIGIT, SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_POW, SYM_OTHER
  } sym_kind_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PUSH_DIG, OP_UNDER, OP_CAP_B, OP_CAP_A,
    OP_ADD, OP_SUB, OP_MUL_P, OP_MUL_R, OP_DIV_INIT, OP_DIV_STEP,
    OP_DIV_FIN, OP_DIV_ZERO, OP_POW_INIT, OP_POW_P, OP_POW_ACC,
    OP_POW_FIN, OP_LAST, OP_PUSH_R, OP_ANS_CAP, OP_ANS_EMPTY, OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {RD_NONE, RD_TOP, RD_NEXT} rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RDB, S_RDA, S_EXEC, S_MUL, S_DIV, S_DIVF,
    S_POWCHK, S_PACC, S_PUSH, S_FINISH, S_RDANS, S_OUT
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd;
  } dp_cmd_t;

  typedef struct packed {
    sym_kind_t kind;
    logic      last;
    logic      sp_lt2;
    logic      sp_zero;
    logic      b_zero;
    logic      div_last;
    logic      pow_done;
    logic      out_free;
  } dp_stat_t;

  function automatic sym_kind_t decode_sym(input logic [7:0] ch);
    sym_kind_t k;
    if (ch >= CH_ZERO && ch <= CH_NINE) k = SYM_DIGIT;
    else if (ch == CH_ADD) k = SYM_ADD;
    else if (ch == CH_SUB) k = SYM_SUB;
    else if (ch == CH_MUL) k = SYM_MUL;
    else if (ch == CH_DIV) k = SYM_DIV;
    else if (ch == CH_POW) k = SYM_POW;
    else k = SYM_OTHER;
    return k;
  endfunction

  // Scale a full product back to Q format, truncating toward zero, then saturate.
  function automatic logic signed [31:0] sat_prod(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic               corr;
    logic signed [31:0] r;
    s    = p >>> FRAC_BITS;
    corr = p[63] && (|(p & LOW_MASK));
    s    = s + $signed({63'd0, corr});
    if (s > MAX64) r = Q_MAX;
    else if (s < MIN64) r = Q_MIN;
    else r = s[31:0];
    return r;
  endfunction

endpackage

// File: src/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/pse_ctrl.sv
// Controller state machine sequencing stack access and arithmetic.
module pse_ctrl import pse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.rd    = RD_NONE;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.kind == SYM_DIGIT) begin
          cmd.op    = OP_PUSH_DIG;
          state_nxt = S_FINISH;
        end else if (stat.sp_lt2) begin
          cmd.op    = OP_UNDER;
          state_nxt = S_FINISH;
        end else begin
          cmd.rd    = RD_TOP;
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        cmd.op    = OP_CAP_B;
        cmd.rd    = RD_NEXT;
        state_nxt = S_RDA;
      end
      S_RDA: begin
        cmd.op    = OP_CAP_A;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (stat.kind)
          SYM_ADD: begin
            cmd.op    = OP_ADD;
            state_nxt = S_PUSH;
          end
          SYM_SUB: begin
            cmd.op    = OP_SUB;
            state_nxt = S_PUSH;
          end
          SYM_MUL: begin
            cmd.op    = OP_MUL_P;
            state_nxt = S_MUL;
          end
          SYM_DIV: begin
            if (stat.b_zero) begin
              cmd.op    = OP_DIV_ZERO;
              state_nxt = S_PUSH;
            end else begin
              cmd.op    = OP_DIV_INIT;
              state_nxt = S_DIV;
            end
          end
          SYM_POW: begin
            cmd.op    = OP_POW_INIT;
            state_nxt = S_POWCHK;
          end
          default: begin
            cmd.op    = OP_LAST;
            state_nxt = S_PUSH;
          end
        endcase
      end
      S_MUL: begin
        cmd.op    = OP_MUL_R;
        state_nxt = S_PUSH;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) state_nxt = S_DIVF;
      end
      S_DIVF: begin
        cmd.op    = OP_DIV_FIN;
        state_nxt = S_PUSH;
      end
      S_POWCHK: begin
        if (stat.pow_done) begin
          cmd.op    = OP_POW_FIN;
          state_nxt = S_PUSH;
        end else begin
          cmd.op    = OP_POW_P;
          state_nxt = S_PACC;
        end
      end
      S_PACC: begin
        cmd.op    = OP_POW_ACC;
        state_nxt = S_POWCHK;
      end
      S_PUSH: begin
        cmd.op    = OP_PUSH_R;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (stat.sp_zero) begin
          cmd.op    = OP_ANS_EMPTY;
          state_nxt = S_OUT;
        end else begin
          cmd.rd    = RD_TOP;
          state_nxt = S_RDANS;
        end
      end
      S_RDANS: begin
        cmd.op    = OP_ANS_CAP;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: src/pse_dp.sv
// Datapath: operand stack, multiplier, serial divider, power loop and output register.
module pse_dp import pse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat
);

  logic [7:0]         sym_r;
  logic               last_r;
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic [1:0]         err_r, err_nxt;
  logic signed [31:0] lastres_r, lastres_nxt;
  logic signed [31:0] a_r, b_r, res_r, acc_r;
  logic signed [63:0] p_r;
  logic [PSW-1:0]     steps_r;
  logic [31:0]        rem_r;
  logic [31:0]        dvs_r;
  logic [QW-1:0]      quo_r;
  logic [CW-1:0]      cnt_r;
  logic               neg_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               flag_en;
  logic [1:0]         flag_code;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;
  logic [SPW-1:0]     sp_m1, sp_m2;
  logic               full;
  logic [31:0]        dig;
  logic signed [32:0] sum;
  logic signed [31:0] add_sat;
  logic signed [31:0] mul_x, mul_y;
  logic [31:0]        ua, ub;
  logic [32:0]        trial, diff;
  logic [32:0]        exp_sum;
  logic [32:0]        raw_steps;
  logic signed [31:0] div_res;

  pse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sp_m1 = sp_r - SPW'(1);
  assign sp_m2 = sp_r - SPW'(2);
  assign full  = (sp_r >= SPW'(STACK_DEPTH));
  assign waddr = sp_r[AW-1:0];
  assign raddr = (cmd.rd == RD_NEXT) ? sp_m2[AW-1:0] : sp_m1[AW-1:0];
  assign dig   = 32'(sym_r - CH_ZERO) << FRAC_BITS;

  assign sum     = (cmd.op == OP_SUB) ? ({a_r[31], a_r} - {b_r[31], b_r})
                                      : ({a_r[31], a_r} + {b_r[31], b_r});
  assign add_sat = (sum[32] != sum[31]) ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];

  assign mul_x = (cmd.op == OP_POW_P) ? acc_r : a_r;
  assign mul_y = (cmd.op == OP_POW_P) ? a_r : b_r;

  assign ua = a_r[31] ? 32'(-a_r) : a_r;
  assign ub = b_r[31] ? 32'(-b_r) : b_r;

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  assign exp_sum   = {1'b0, b_r} + 33'((64'd1 << FRAC_BITS) - 64'd1);
  assign raw_steps = exp_sum >> FRAC_BITS;

  always_comb begin
    if (!neg_r) begin
      div_res = (quo_r > QMAX_MAG) ? Q_MAX : quo_r[31:0];
    end else begin
      div_res = (quo_r > QMIN_MAG) ? Q_MIN : 32'(-quo_r[31:0]);
    end
  end

  always_comb begin
    we          = 1'b0;
    wdata       = res_r;
    flag_en     = 1'b0;
    flag_code   = ST_OK;
    sp_nxt      = sp_r;
    lastres_nxt = lastres_r;
    case (cmd.op)
      OP_PUSH_DIG: begin
        wdata = dig;
        if (full) begin
          flag_en   = 1'b1;
          flag_code = ST_OVER;
        end else begin
          we     = 1'b1;
          sp_nxt = sp_r + SPW'(1);
        end
      end
      OP_PUSH_R: begin
        lastres_nxt = res_r;
        if (full) begin
          flag_en   = 1'b1;
          flag_code = ST_OVER;
        end else begin
          we     = 1'b1;
          sp_nxt = sp_r + SPW'(1);
        end
      end
      OP_UNDER, OP_ANS_EMPTY: begin
        flag_en   = 1'b1;
        flag_code = ST_UNDER;
      end
      OP_DIV_ZERO: begin
        flag_en   = 1'b1;
        flag_code = ST_DIV0;
      end
      OP_CAP_A: sp_nxt = sp_m2;
      OP_OUT: begin
        sp_nxt      = '0;
        lastres_nxt = '0;
      end
      default: ;
    endcase
    err_nxt = (flag_en && err_r == ST_OK) ? flag_code : err_r;
    if (cmd.op == OP_OUT) err_nxt = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      err_r       <= ST_OK;
      lastres_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r      <= sp_nxt;
      err_r     <= err_nxt;
      lastres_r <= lastres_nxt;
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        sym_r  <= in_data.symbol;
        last_r <= in_data.last_symbol;
      end
      OP_CAP_B: b_r <= rdata;
      OP_CAP_A: a_r <= rdata;
      OP_ADD, OP_SUB: res_r <= add_sat;
      OP_MUL_P, OP_POW_P: p_r <= mul_x * mul_y;
      OP_MUL_R: res_r <= sat_prod(p_r);
      OP_DIV_ZERO: res_r <= (a_r == 32'sd0) ? 32'sd0 : (a_r[31] ? Q_MIN : Q_MAX);
      OP_DIV_INIT: begin
        rem_r <= '0;
        dvs_r <= ub;
        quo_r <= QW'(ua) << FRAC_BITS;
        cnt_r <= CW'(QW);
        neg_r <= a_r[31] ^ b_r[31];
      end
      OP_DIV_STEP: begin
        // remainder stays below the divisor, so its top bit is never needed
        if (!diff[32]) begin
          rem_r <= diff[31:0];
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
      end
      OP_DIV_FIN: res_r <= div_res;
      OP_POW_INIT: begin
        acc_r <= 32'(64'd1 << FRAC_BITS);
        if (b_r[31] || b_r == 32'sd0) steps_r <= '0;
        else if (raw_steps > 33'(MAX_POWER_STEPS)) steps_r <= PSW'(MAX_POWER_STEPS);
        else steps_r <= raw_steps[PSW-1:0];
      end
      OP_POW_ACC: begin
        acc_r   <= sat_prod(p_r);
        steps_r <= steps_r - PSW'(1);
      end
      OP_POW_FIN: res_r <= acc_r;
      OP_LAST: res_r <= lastres_r;
      OP_ANS_CAP: res_r <= rdata;
      OP_ANS_EMPTY: res_r <= '0;
      OP_OUT: begin
        out_r.value  <= res_r;
        out_r.status <= err_r;
      end
      default: ;
    endcase
  end

  assign stat.kind     = decode_sym(sym_r);
  assign stat.last     = last_r;
  assign stat.sp_lt2   = (sp_r < SPW'(2));
  assign stat.sp_zero  = (sp_r == '0);
  assign stat.b_zero   = (b_r == 32'sd0);
  assign stat.div_last = (cnt_r == CW'(1));
  assign stat.pow_done = (steps_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/postfix_stack_evaluator_top.sv
// Postfix expression evaluator on a 16-entry operand stack, signed Q16.16.
//
// Input channel (in_valid/in_stall/in_data): one ASCII character per transfer,
// last_symbol marks the end of an expression. Output channel (out_valid/
// out_stall/out_data): one result per expression with value and status.
// Items are processed one at a time; in_stall is high while a character is
// being worked on.
// Per character: a digit is pushed at once, an operator on fewer than two
// entries flags underflow, and +,- and other operators read both operands and
// execute; multiply registers the product, then scales it; divide makes one
// quotient bit per cycle over 48 bits in the restoring divider; power repeats
// multiplications (up to 31, one multiplier reused). A last character adds a
// fetch of the answer (none on an empty stack) and a load of the output register.
// The output register frees the stack for the next expression; a new result
// waits in the controller until the previous one is transferred, so a stalled
// receiver holds the whole block only once a second answer is ready.
// Reset (rst_n low, synchronous) empties the stack, clears the last result and
// error code, and drops out_valid. Stack contents are not cleared; only entries
// below the stack pointer are ever read.
module postfix_stack_evaluator_top import pse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pse_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: src/pse_checker.sv
// Port-level assertions for the postfix stack evaluator, bound to the top level.
module pse_checker import pse_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // A character transfer keeps the block busy for the next cycle.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous character in flight");

  // Reset drops any pending result.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: dv/postfix_stack_evaluator_checker.sv
// Checker: predicts postfix evaluator answers from the input stream and compares them.
module postfix_stack_evaluator_checker import pse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_answers
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] opnd_stack [STACK_DEPTH];
  int                 depth_used;
  logic signed [31:0] recent_result;
  logic [1:0]         expr_error;
  out_item_t          answer_q[$];

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return clamp32(p / (64'sd1 <<< FRAC_BITS));
  endfunction

  task automatic note_error(input logic [1:0] code);
    if (expr_error == ST_OK) expr_error = code;
  endtask

  task automatic push_value(input logic signed [31:0] v);
    if (depth_used >= STACK_DEPTH) note_error(ST_OVER);
    else begin
      opnd_stack[depth_used] = v;
      depth_used++;
    end
  endtask

  task automatic clear_expr();
    depth_used = 0;
    recent_result = 0;
    expr_error = ST_OK;
  endtask

  task automatic evaluate_symbol(input in_item_t it);
    logic signed [31:0] a, b, r;
    logic signed [63:0] steps;
    out_item_t ans;
    if (it.symbol >= CH_ZERO && it.symbol <= CH_NINE)
      push_value(clamp32(64'(it.symbol - CH_ZERO) <<< FRAC_BITS));
    else if (depth_used < 2) note_error(ST_UNDER);
    else begin
      b = opnd_stack[depth_used-1];
      a = opnd_stack[depth_used-2];
      depth_used -= 2;
      case (it.symbol)
        CH_ADD: r = clamp32(64'(a) + 64'(b));
        CH_SUB: r = clamp32(64'(a) - 64'(b));
        CH_MUL: r = q_mul(a, b);
        CH_DIV: begin
          if (b == 0) begin
            note_error(ST_DIV0);
            r = (a == 0) ? 32'sd0 : (a > 0 ? Q_MAX : Q_MIN);
          end else r = clamp32((64'(a) <<< FRAC_BITS) / 64'(b));
        end
        CH_POW: begin
          steps = 0;
          if (b > 0) steps = (64'(b) + (64'sd1 <<< FRAC_BITS) - 1) / (64'sd1 <<< FRAC_BITS);
          if (steps > MAX_POWER_STEPS) steps = MAX_POWER_STEPS;
          r = clamp32(64'sd1 <<< FRAC_BITS);
          for (int i = 0; i < steps; i++) r = q_mul(r, a);
        end
        default: r = recent_result;
      endcase
      recent_result = r;
      push_value(r);
    end
    if (it.last_symbol) begin
      ans.value = 0;
      if (depth_used == 0) note_error(ST_UNDER);
      else ans.value = opnd_stack[depth_used-1];
      ans.status = expr_error;
      answer_q.push_back(ans);
      clear_expr();
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_ans;
    if (!rst_n) begin
      clear_expr();
      answer_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) evaluate_symbol(in_data);
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected answer %h/%0d", out_data.value, out_data.status);
        end else begin
          exp_ans = answer_q.pop_front();
          if (exp_ans != out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("answer mismatch: exp %h/%0d got %h/%0d", exp_ans.value,
                       exp_ans.status, out_data.value, out_data.status);
          end
        end
      end
    end
    pending_answers <= answer_q.size();
  end

endmodule

// File: dv/postfix_stack_evaluator_top_tb.sv
// Testbench top: drives postfix expressions into the evaluator and gives the verdict.
module postfix_stack_evaluator_top_tb import pse_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;
  int        fail_count, pending_answers;
  bit        long_hold = 0;
  bit        hold_done = 0;
  int        hold_cnt = 0;
  int        idle_cycles = 0;
  in_item_t  sym_q[$];

  always #1 clk = ~clk;

  postfix_stack_evaluator_top uut (.*);

  postfix_stack_evaluator_checker chk (.*);

  // receiver stall pattern, with one long hold-off counted here once requested
  always @(posedge clk) begin
    if (long_hold && !hold_done) begin
      out_stall <= 1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1;
    end else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("postfix_stack_evaluator_top_tb: errors");
      $finish;
    end
  end

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 6))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      3: return CH_DIV;
      4: return CH_POW;
      5: return 8'($urandom_range(0, 255));
      default: return CH_SUB;
    endcase
  endfunction

  task automatic add_expr(input string s);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.symbol = s[i];
      it.last_symbol = (i == s.len() - 1);
      sym_q.push_back(it);
    end
  endtask

  // well-formed expression with random content, or noise
  task automatic add_random_expr();
    in_item_t it;
    int n, d;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        it.symbol = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : rand_digit();
        it.last_symbol = (i == n - 1);
        sym_q.push_back(it);
      end
    end else begin
      d = 0;
      n = $urandom_range(1, 8);
      for (int i = 0; i < 2 * n - 1; i++) begin
        if (d >= 2 && (d >= 6 || $urandom_range(0, 1))) begin
          it.symbol = rand_op();
          d--;
        end else begin
          it.symbol = rand_digit();
          d++;
        end
        it.last_symbol = 0;
        sym_q.push_back(it);
      end
      while (d > 1) begin
        it.symbol = rand_op();
        it.last_symbol = 0;
        sym_q.push_back(it);
        d--;
      end
      sym_q[$].last_symbol = 1;
    end
  endtask

  task automatic send_symbol(input in_item_t it);
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int burst;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    // directed: every operator, extremes, each error kind
    add_expr("12+");
    add_expr("93-");
    add_expr("99*9*9*9*9*");
    add_expr("72/");
    add_expr("50/");
    add_expr("00/");
    add_expr("05-0/");
    add_expr("29^");
    add_expr("20^");
    add_expr("99*9*9*9*9*99*9*9*9*9*-");
    add_expr("34~");
    add_expr("+");
    add_expr("1+");
    add_expr("0123456789012345678");
    add_expr("\xff");
    add_expr("8");
    add_expr("22+\x00");
    while (sym_q.size() > 0) send_symbol(sym_q.pop_front());
    in_valid <= 0;
    // pause until the block has drained
    @(posedge clk);
    while (pending_answers != 0) @(posedge clk);
    for (int n = 0; n < 800;) begin
      if (sym_q.size() == 0) add_random_expr();
      burst = $urandom_range(1, 30);
      if (n > 300 && n < 340) begin
        long_hold <= 1;
        burst = 40;
      end
      for (int i = 0; i < burst && sym_q.size() > 0; i++) begin
        send_symbol(sym_q.pop_front());
        n++;
        if (sym_q.size() == 0 && n < 800) add_random_expr();
      end
      in_valid <= 0;
      repeat ($urandom_range(0, 8)) @(posedge clk);
    end
    while (sym_q.size() > 0) send_symbol(sym_q.pop_front());
    in_valid <= 0;
    @(posedge clk);
    while (pending_answers != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("postfix_stack_evaluator_top_tb: clean");
    else $display("postfix_stack_evaluator_top_tb: errors");
    $finish;
  end
endmodule
